>>> rtl/core/qda_pkg.sv
// Package for the quantized diamond angle block.
// Cell word type, divider step count and the quadrant mapping functions.
// No dependencies.
package qda_pkg;

   localparam int unsigned DIV_STEPS = 6;
   localparam int unsigned COMP_W = 16;
   localparam int unsigned STEP_W = 6;
   localparam int unsigned RATIO_W = 7;

   localparam logic [STEP_W-1:0] HEADING_STEPS = 6'd48;
   localparam logic [STEP_W-1:0] ROLL_STEPS = 6'd60;
   localparam logic [STEP_W-1:0] HEADING_HALF = 6'd24;
   localparam logic [STEP_W-1:0] ROLL_HALF = 6'd30;
   localparam logic [RATIO_W-1:0] RATIO_FULL = 7'd64;
   localparam logic [3:0] ROLL_Q_MAX = 4'd15;

   localparam logic FUNC_HEADING = 1'b0;
   localparam logic FUNC_ROLL = 1'b1;

   typedef struct packed {
      logic func;
      logic a_neg;
      logic b_neg;
      logic full;
      logic [COMP_W-1:0] num;
      logic [COMP_W-1:0] den;
      logic [DIV_STEPS-1:0] quo;
   } cell_word_type;

   // floor(r/5) for r <= 64 via reciprocal 205/1024
   function automatic logic [3:0] ratio_div5(input logic [RATIO_W-1:0] r);
      logic [14:0] prod;
      prod = {8'b0, r} * 15'd205;
      return prod[13:10];
   endfunction

   function automatic logic [STEP_W-1:0] map_step(input logic func, input logic a_neg,
                                                  input logic b_neg,
                                                  input logic [RATIO_W-1:0] r);
      logic [STEP_W-1:0] q;
      logic [STEP_W-1:0] step;
      step = '0;
      if (func == FUNC_HEADING) begin
         q = {2'b0, ratio_div5(r)};
         if (!a_neg) begin
            if (b_neg) step = q;
            else step = (q != '0) ? HEADING_STEPS - q : '0;
         end else begin
            step = b_neg ? HEADING_HALF - q : HEADING_HALF + q;
         end
      end else begin
         q = (r[6:2] > {1'b0, ROLL_Q_MAX}) ? {2'b0, ROLL_Q_MAX} : {1'b0, r[6:2]};
         if (!a_neg) begin
            if (!b_neg) step = q;
            else step = (q != '0) ? ROLL_STEPS - q : '0;
         end else begin
            step = !b_neg ? ROLL_HALF - q : ROLL_HALF + q;
         end
      end
      return step;
   endfunction

endpackage

>>> rtl/core/qda_front.sv
// Entry cell: magnitudes, wrapped sum, special cases and halving.
// Depends on qda_pkg.
module qda_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       in_func,
   input  logic signed [15:0]         in_a,
   input  logic signed [15:0]         in_b,
   output logic                       out_valid,
   input  logic                       out_ready,
   output qda_pkg::cell_word_type     out_word
);
   import qda_pkg::*;

   logic valid_ff;
   cell_word_type word_ff, word_in;
   logic [COMP_W-1:0] ma, mb, sum;
   logic zero, half;

   always_comb begin
      ma = in_a[15] ? (~in_a) + 16'd1 : in_a;
      mb = in_b[15] ? (~in_b) + 16'd1 : in_b;
      sum = ma + mb;
      zero = (sum == '0);
      half = sum[15];
      word_in.func = in_func;
      word_in.a_neg = in_a[15];
      word_in.b_neg = in_b[15];
      word_in.full = (ma == '0) && !zero;
      word_in.num = zero ? '0 : (half ? {1'b0, mb[15:1]} : mb);
      word_in.den = zero ? 16'd1 : (half ? {1'b0, sum[15:1]} : sum);
      word_in.quo = '0;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word = word_ff;
endmodule

>>> rtl/core/qda_div_cell.sv
// One restoring shift-subtract step of the ratio divider.
// Depends on qda_pkg.
module qda_div_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  qda_pkg::cell_word_type     in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output qda_pkg::cell_word_type     out_word
);
   import qda_pkg::*;

   logic valid_ff;
   cell_word_type word_ff, word_in;
   logic [COMP_W-1:0] sh;
   logic ge;

   always_comb begin
      sh = {in_word.num[COMP_W-2:0], 1'b0};
      ge = (sh >= in_word.den);
      word_in = in_word;
      word_in.num = ge ? sh - in_word.den : sh;
      word_in.quo = {in_word.quo[DIV_STEPS-2:0], ge};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word = word_ff;
endmodule

>>> rtl/core/qda_map.sv
// Output cell: ratio to quadrant step, registered result word.
// Depends on qda_pkg.
module qda_map (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  qda_pkg::cell_word_type     in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [qda_pkg::STEP_W-1:0] out_step
);
   import qda_pkg::*;

   logic valid_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RATIO_W-1:0] ratio;

   always_comb begin
      ratio = in_word.full ? RATIO_FULL : {1'b0, in_word.quo};
      step_in = map_step(in_word.func, in_word.a_neg, in_word.b_neg, ratio);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         step_ff <= step_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_step = step_ff;
endmodule

>>> rtl/core/quantized_diamond_angle_top.sv
// Quantized diamond angle: top level, chain of entry, divider and output cells.
// Depends on qda_pkg, qda_front, qda_div_cell, qda_map.
//
// Usage:
//   Request word: req_func (0 heading, 48 steps; 1 roll, 60 steps) and the two
//   signed 16-bit components. Taken when req_valid and req_ready are high.
//   Response word: rsp_angle_step, taken when rsp_valid and rsp_ready are high.
//   Pipeline: eight register cells (one entry cell, six divider cells each
//   resolving one quotient bit, one output cell); an accepted word moves
//   through them in that order, and rsp_valid rises when it reaches the output cell.
//   Throughput: one word per cycle while rsp_ready stays high; each cell is a
//   register stage that passes its word on every cycle its neighbor can take it.
//   Stall: each cell is ready when empty or when its neighbor is ready, so a
//   stalled receiver fills the chain bubble by bubble; req_ready drops only
//   when all eight cells hold words.
//   Reset: synchronous, clears all cell valid flags; no words in flight.
module quantized_diamond_angle_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic signed [15:0]         req_first_component,
   input  logic signed [15:0]         req_second_component,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [qda_pkg::STEP_W-1:0] rsp_angle_step
);
   import qda_pkg::*;

   logic          valid_c [DIV_STEPS+1];
   logic          ready_c [DIV_STEPS+1];
   cell_word_type word_c  [DIV_STEPS+1];

   qda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_func   (req_func),
      .in_a      (req_first_component),
      .in_b      (req_second_component),
      .out_valid (valid_c[0]),
      .out_ready (ready_c[0]),
      .out_word  (word_c[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      qda_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_c[i]),
         .in_ready  (ready_c[i]),
         .in_word   (word_c[i]),
         .out_valid (valid_c[i+1]),
         .out_ready (ready_c[i+1]),
         .out_word  (word_c[i+1])
      );
   end

   qda_map u_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_c[DIV_STEPS]),
      .in_ready  (ready_c[DIV_STEPS]),
      .in_word   (word_c[DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_step  (rsp_angle_step)
   );
endmodule

>>> rtl/core/qda_checker.sv
// Port-level checks for quantized_diamond_angle_top, bound to the top level.
// Depends on qda_pkg.
module qda_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [qda_pkg::STEP_W-1:0] rsp_angle_step
);
   import qda_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle_step))
      else $error("response word changed while stalled");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_step < ROLL_STEPS)
      else $error("angle step out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked while output cell empty");
endmodule

bind quantized_diamond_angle_top qda_checker u_qda_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_angle_step (rsp_angle_step)
);

>>> tb/qda_angle_checker.sv
// Checker for the quantized diamond angle block: watches both channels,
// predicts the angle step of every accepted request word and compares in order.
// Depends on qda_pkg.
module qda_angle_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_func,
   input  logic [15:0]                req_first_component,
   input  logic [15:0]                req_second_component,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [qda_pkg::STEP_W-1:0] rsp_angle_step,
   output int                         mismatch_count,
   output int                         in_flight
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] HALVE_LIMIT = 16'd32767;

   typedef struct {
      logic                       func;
      logic [15:0]                comp_a;
      logic [15:0]                comp_b;
      logic [qda_pkg::STEP_W-1:0] step;
   } angle_expect_type;

   angle_expect_type expected_steps[$];

   function automatic logic [qda_pkg::STEP_W-1:0] diamond_step(input logic func,
                                                               input logic [15:0] a,
                                                               input logic [15:0] b);
      logic [15:0] mag_a;
      logic [15:0] mag_b;
      logic [15:0] sum;
      logic [15:0] num;
      logic [15:0] den;
      logic [qda_pkg::RATIO_W-1:0] ratio;
      logic [qda_pkg::STEP_W-1:0] q;
      logic [qda_pkg::STEP_W-1:0] step;
      mag_a = a[15] ? ~a + 16'd1 : a;
      mag_b = b[15] ? ~b + 16'd1 : b;
      sum = mag_a + mag_b;
      ratio = '0;
      if (sum == '0) begin
         ratio = '0;
      end else if (mag_b == sum) begin
         ratio = qda_pkg::RATIO_FULL;
      end else begin
         num = mag_b;
         den = sum;
         if (den > HALVE_LIMIT) begin
            num = num >> 1;
            den = den >> 1;
         end
         for (int i = 0; i < qda_pkg::DIV_STEPS; i++) begin
            num = num << 1;
            ratio = {ratio[qda_pkg::RATIO_W-2:0], 1'b0};
            if (num >= den) begin
               num = num - den;
               ratio[0] = 1'b1;
            end
         end
      end
      if (func == qda_pkg::FUNC_HEADING) begin
         q = qda_pkg::STEP_W'(ratio / 7'd5);
         if (!a[15])
            step = b[15] ? q : ((q != '0) ? qda_pkg::HEADING_STEPS - q : '0);
         else
            step = b[15] ? qda_pkg::HEADING_HALF - q : qda_pkg::HEADING_HALF + q;
      end else begin
         q = qda_pkg::STEP_W'(ratio / 7'd4);
         if (q > qda_pkg::STEP_W'(qda_pkg::ROLL_Q_MAX))
            q = qda_pkg::STEP_W'(qda_pkg::ROLL_Q_MAX);
         if (!a[15])
            step = !b[15] ? q : ((q != '0) ? qda_pkg::ROLL_STEPS - q : '0);
         else
            step = !b[15] ? qda_pkg::ROLL_HALF - q : qda_pkg::ROLL_HALF + q;
      end
      return step;
   endfunction

   always @(posedge clock) begin
      angle_expect_type head;
      angle_expect_type fresh;
      int popped;
      int pushed;
      popped = 0;
      pushed = 0;
      if (reset) begin
         expected_steps.delete();
         mismatch_count <= 0;
         in_flight <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_steps.size() == 0) begin
               $display("%0t: unexpected response word: expected none, got step %0d",
                        $realtime, rsp_angle_step);
               mismatch_count <= mismatch_count + 1;
            end else begin
               head = expected_steps.pop_front();
               popped = 1;
               if (rsp_angle_step !== head.step) begin
                  $display({"%0t: angle_step mismatch (func %0d a %0d b %0d): ",
                            "expected %0d, got %0d"},
                           $realtime, head.func, $signed(head.comp_a),
                           $signed(head.comp_b), head.step, rsp_angle_step);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            fresh.func = req_func;
            fresh.comp_a = req_first_component;
            fresh.comp_b = req_second_component;
            fresh.step = diamond_step(req_func, req_first_component, req_second_component);
            expected_steps.push_back(fresh);
            pushed = 1;
         end
         in_flight <= in_flight + pushed - popped;
      end
   end

endmodule

>>> tb/quantized_diamond_angle_top_test.sv
// Testbench top for quantized_diamond_angle_top: clock, reset and request/response
// traffic: directed corners, then several idle/stall mixes; checking is done by qda_angle_checker.
// Depends on qda_pkg, quantized_diamond_angle_top, qda_angle_checker.
module quantized_diamond_angle_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 120;
   localparam int WORDS_PER_PHASE = 100;
   localparam int NUM_DIRECTED = 13;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_func;
   logic [15:0]                req_first_component;
   logic [15:0]                req_second_component;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [qda_pkg::STEP_W-1:0] rsp_angle_step;

   int mismatch_count;
   int in_flight;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_now = 1'b0;
   int heading_words = 0;
   int roll_words = 0;

   int dir_a[NUM_DIRECTED] = '{0, -32768, 0, 0, -32768, 32767, 32767, 1, 3, 3, -3, -3, 1000};
   int dir_b[NUM_DIRECTED] = '{0, -32768, 5, -32768, 0, 0, 32767, -32768, 4, -4, 4, -4, -1};
   int phase_idle[4] = '{0, 68, 0, 33};
   int phase_stall[4] = '{0, 0, 68, 33};

   quantized_diamond_angle_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_first_component  (req_first_component),
      .req_second_component (req_second_component),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_angle_step       (rsp_angle_step)
   );

   qda_angle_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_first_component  (req_first_component),
      .req_second_component (req_second_component),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_angle_step       (rsp_angle_step),
      .mismatch_count       (mismatch_count),
      .in_flight            (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d words still outstanding", cycle_count, in_flight);
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_now) begin
            hold_now = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic logic [15:0] pick_component();
      logic [15:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = 16'($urandom);
         4, 5: begin
            v = 16'($urandom_range(40));
            if ($urandom_range(1) == 1) v = ~v + 16'd1;
         end
         6: v = '0;
         7: v = ($urandom_range(1) == 1) ? 16'h8000 : 16'h7FFF;
         default: begin
            v = 16'($urandom_range(16'h7FFF, 16'h4000));
            if ($urandom_range(1) == 1) v = ~v + 16'd1;
         end
      endcase
      return v;
   endfunction

   task automatic send_word(input logic func, input logic [15:0] a, input logic [15:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_first_component <= a;
      req_second_component <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (func == qda_pkg::FUNC_HEADING) heading_words++;
      else roll_words++;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
   endtask

   initial begin
      int failures;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= qda_pkg::FUNC_HEADING;
      req_first_component <= '0;
      req_second_component <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_word(qda_pkg::FUNC_HEADING, 16'(dir_a[i]), 16'(dir_b[i]));
         send_word(qda_pkg::FUNC_ROLL, 16'(dir_a[i]), 16'(dir_b[i]));
      end
      drain_all();

      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         // long output hold-off with back-to-back input fills the pipe
         if (p == 0) hold_now = 1'b1;
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(logic'($urandom_range(1)), pick_component(), pick_component());
         drain_all();
      end
      repeat (12) @(posedge clock);

      failures = mismatch_count + in_flight;
      $display("Checked %0d heading and %0d roll words: directed corners, then four idle/stall mixes",
               heading_words, roll_words);
      $display("including a %0d-cycle output hold-off and full drains between phases", HOLD_CYCLES);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/qda_pkg.sv
rtl/core/qda_front.sv
rtl/core/qda_div_cell.sv
rtl/core/qda_map.sv
rtl/core/quantized_diamond_angle_top.sv
rtl/core/qda_checker.sv
tb/qda_angle_checker.sv
tb/quantized_diamond_angle_top_test.sv
